// ----- hw/rtl/i2c_master_register_access_defines.svh -----
// Assertion macros for the I2C register access master.
// Depends on nothing; included by the top level, which writes its checks with them.
`ifndef I2C_MASTER_REGISTER_ACCESS_DEFINES_SVH
`define I2C_MASTER_REGISTER_ACCESS_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Plain property, checked at every clock edge outside reset.
`define I2CRA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Antecedent implies consequent in the following clock cycle.
`define I2CRA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define I2CRA_ASSERT(lbl, clk, rst, prop, msg)
`define I2CRA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// ----- hw/rtl/i2cra_pkg.sv -----
// Types and constants shared by the I2C register access master.
// No dependencies; compiled first.
`default_nettype none

package i2cra_pkg;

   // command codes on the request channel
   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_LOAD  = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;

   localparam logic [7:0] MSB_MASK = 8'h80;

   localparam logic [6:0] DEV_ADDR_RESET = 7'd81;

   typedef struct packed {
      logic [1:0] op;
      logic       read_not_write;
      logic [7:0] register_address;
      logic [3:0] byte_count;
      logic [7:0] write_data;
      logic       sda_sample;
   } req_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic [7:0] read_data;
      logic       read_valid;
      logic       busy_res;
      logic       done_res;
      logic       nack_error;
   } rsp_type;

   typedef struct packed {
      logic [6:0] device_address;
   } csr_type;

endpackage

`default_nettype wire

// ----- hw/rtl/i2cra_chan_if.sv -----
// Valid/ready channel carrying one beat of a given payload type.
// Depends on i2cra_pkg for the payload types it is instantiated with.
`default_nettype none

interface i2cra_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/i2c_master_register_access.sv -----
// I2C master running one register read or write per start command.
// Depends on i2cra_pkg, i2cra_chan_if and i2c_master_register_access_defines.svh.
//
// Use:
//  - csr_if : one-register write port (device_address, 7 bits, reset 81). Always
//             ready; write only while no transaction is running.
//  - req_if : command beats. op START latches direction, register and byte count;
//             op LOAD queues a write byte (idle only, up to MAX_BYTES); op TICK
//             advances the bus by one timing slot and produces one rsp beat.
//  - rsp_if : one beat per TICK with the SCL/SDA levels for that slot, received
//             byte strobe, busy, done and NACK error flags.
// Timing: one command beat per cycle is sustained while rsp_if takes result
// beats. A TICK's result sits in the output register from the next cycle.
// The next slot depends only on registered phase and counters, so there is no
// internal loop slowing things down.
// Stall: req_if.ready drops only while the output register holds a beat that
// rsp_if has not taken; a new TICK may be accepted in the same cycle the held
// beat leaves.
// Reset (synchronous, active high): bus released (SCL=SDA=1), phase idle, load
// pointer cleared, device_address back to 81. The write buffer is not cleared;
// a write must only send bytes loaded since the previous start.
`default_nettype none

`include "i2c_master_register_access_defines.svh"

module i2c_master_register_access #(
   parameter int MAX_BYTES = 8
) (
   input  wire               clock,
   input  wire               reset,
   i2cra_chan_if.sink        req_if,
   i2cra_chan_if.source      rsp_if,
   i2cra_chan_if.sink        csr_if
);
   import i2cra_pkg::*;

   localparam int CNT_W = $clog2(MAX_BYTES + 1);
   localparam int IDX_W = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;

   // bus phases
   localparam logic [2:0] PH_IDLE  = 3'd0;
   localparam logic [2:0] PH_START = 3'd1;
   localparam logic [2:0] PH_SEND  = 3'd2;
   localparam logic [2:0] PH_SACK  = 3'd3;
   localparam logic [2:0] PH_RECV  = 3'd4;
   localparam logic [2:0] PH_RACK  = 3'd5;
   localparam logic [2:0] PH_STOP  = 3'd6;

   // which byte of the transaction is on the wire
   localparam logic [1:0] STG_ADDRW = 2'd0;
   localparam logic [1:0] STG_REG   = 2'd1;
   localparam logic [1:0] STG_WDATA = 2'd2;
   localparam logic [1:0] STG_ADDRR = 2'd3;

   req_type             req;
   logic                req_accept;
   logic                tick;

   logic [2:0]          phase_ff, phase_in;
   logic [1:0]          slot_ff, slot_in;
   logic [2:0]          bit_ff, bit_in;
   logic [CNT_W-1:0]    byte_idx_ff, byte_idx_in;
   logic [7:0]          shift_ff, shift_in;
   logic [CNT_W-1:0]    load_ptr_ff, load_ptr_in;
   logic                dir_ff, dir_in;
   logic [7:0]          treg_ff, treg_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                scl_ff, scl_in;
   logic                sda_ff, sda_in;
   logic [1:0]          stage_ff, stage_in;
   logic                nack_ff, nack_in;
   logic [6:0]          dev_addr_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   // write buffer, with a registered read port prefetching the next byte to send
   logic [7:0]          wbuf_mem [MAX_BYTES];
   logic [7:0]          wbuf_q_ff;
   logic [IDX_W-1:0]    wbuf_rd_addr;
   logic                wbuf_wr_en;

   assign req          = req_if.data;
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign req_accept   = req_if.valid && req_if.ready;
   assign csr_if.ready = 1'b1;

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.data  = rsp_data_ff;

   // Stage REG hands over to byte 0; during data bytes the next one is fetched.
   assign wbuf_rd_addr = (stage_ff == STG_WDATA) ?
                         IDX_W'(byte_idx_ff + CNT_W'(1)) : '0;

   always_ff @(posedge clock) begin
      if (wbuf_wr_en) begin
         wbuf_mem[load_ptr_ff[IDX_W-1:0]] <= req.write_data;
      end
      wbuf_q_ff <= wbuf_mem[wbuf_rd_addr];
   end

   always_comb begin
      logic scl, sda, rd_v, busy, done, nerr;
      logic [7:0] rd;
      logic [7:0] recv_byte;

      phase_in    = phase_ff;
      slot_in     = slot_ff;
      bit_in      = bit_ff;
      byte_idx_in = byte_idx_ff;
      shift_in    = shift_ff;
      load_ptr_in = load_ptr_ff;
      dir_in      = dir_ff;
      treg_in     = treg_ff;
      count_in    = count_ff;
      scl_in      = scl_ff;
      sda_in      = sda_ff;
      stage_in    = stage_ff;
      nack_in     = nack_ff;
      wbuf_wr_en  = 1'b0;
      tick        = 1'b0;

      scl  = 1'b1;
      sda  = 1'b1;
      rd   = 8'd0;
      rd_v = 1'b0;
      busy = 1'b1;
      done = 1'b0;
      nerr = 1'b0;
      recv_byte = {shift_ff[6:0], req.sda_sample};

      if (req_accept) begin
         case (req.op)
            OP_START: begin
               if (phase_ff == PH_IDLE) begin
                  dir_in      = req.read_not_write;
                  treg_in     = req.register_address;
                  count_in    = (32'(req.byte_count) > MAX_BYTES) ?
                                CNT_W'(MAX_BYTES) : CNT_W'(req.byte_count);
                  load_ptr_in = '0;
                  nack_in     = 1'b0;
                  byte_idx_in = '0;
                  stage_in    = STG_ADDRW;
                  slot_in     = 2'd0;
                  phase_in    = PH_START;
               end
            end
            OP_LOAD: begin
               if (phase_ff == PH_IDLE && 32'(load_ptr_ff) < MAX_BYTES) begin
                  wbuf_wr_en  = 1'b1;
                  load_ptr_in = load_ptr_ff + CNT_W'(1);
               end
            end
            OP_TICK: begin
               tick = 1'b1;
               unique case (phase_ff)
                  PH_START: begin
                     scl = (slot_ff < 2'd2);
                     sda = (slot_ff == 2'd0);
                     if (slot_ff >= 2'd2) begin
                        shift_in = {dev_addr_ff, stage_ff == STG_ADDRR};
                        bit_in   = 3'd0;
                        slot_in  = 2'd0;
                        phase_in = PH_SEND;
                     end else begin
                        slot_in = slot_ff + 2'd1;
                     end
                  end
                  PH_SEND: begin
                     sda = |(shift_ff & MSB_MASK);
                     scl = (slot_ff == 2'd1);
                     if (slot_ff >= 2'd2) begin
                        shift_in = {shift_ff[6:0], 1'b0};
                        slot_in  = 2'd0;
                        if (bit_ff == 3'd7) begin
                           bit_in   = 3'd0;
                           phase_in = PH_SACK;
                        end else begin
                           bit_in = bit_ff + 3'd1;
                        end
                     end else begin
                        slot_in = slot_ff + 2'd1;
                     end
                  end
                  PH_SACK: begin
                     sda = 1'b1;
                     scl = (slot_ff == 2'd1);
                     if (slot_ff == 2'd1 && req.sda_sample) begin
                        nack_in = 1'b1;
                     end
                     if (slot_ff >= 2'd2) begin
                        slot_in = 2'd0;
                        if (nack_ff) begin
                           phase_in = PH_STOP;
                        end else begin
                           unique case (stage_ff)
                              STG_ADDRW: begin
                                 stage_in = STG_REG;
                                 shift_in = treg_ff;
                                 bit_in   = 3'd0;
                                 phase_in = PH_SEND;
                              end
                              STG_REG: begin
                                 if (dir_ff) begin
                                    stage_in = STG_ADDRR;
                                    phase_in = PH_START;
                                 end else if (count_ff == '0) begin
                                    phase_in = PH_STOP;
                                 end else begin
                                    stage_in    = STG_WDATA;
                                    byte_idx_in = '0;
                                    shift_in    = wbuf_q_ff;
                                    bit_in      = 3'd0;
                                    phase_in    = PH_SEND;
                                 end
                              end
                              STG_WDATA: begin
                                 byte_idx_in = byte_idx_ff + CNT_W'(1);
                                 if (byte_idx_in < count_ff) begin
                                    shift_in = wbuf_q_ff;
                                    bit_in   = 3'd0;
                                    phase_in = PH_SEND;
                                 end else begin
                                    phase_in = PH_STOP;
                                 end
                              end
                              default: begin
                                 // address+R acknowledged: start receiving, or stop if no bytes are to be read
                                 if (count_ff == '0) begin
                                    phase_in = PH_STOP;
                                 end else begin
                                    byte_idx_in = '0;
                                    bit_in      = 3'd0;
                                    shift_in    = 8'd0;
                                    phase_in    = PH_RECV;
                                 end
                              end
                           endcase
                        end
                     end else begin
                        slot_in = slot_ff + 2'd1;
                     end
                  end
                  PH_RECV: begin
                     sda = 1'b1;
                     scl = (slot_ff == 2'd0);
                     if (slot_ff == 2'd0) begin
                        shift_in = recv_byte;
                        if (bit_ff == 3'd7) begin
                           rd_v = 1'b1;
                           rd   = recv_byte;
                        end
                        slot_in = 2'd1;
                     end else begin
                        slot_in = 2'd0;
                        if (bit_ff == 3'd7) begin
                           bit_in   = 3'd0;
                           phase_in = PH_RACK;
                        end else begin
                           bit_in = bit_ff + 3'd1;
                        end
                     end
                  end
                  PH_RACK: begin
                     // ACK every byte but the last
                     sda = !(({1'b0, byte_idx_ff} + (CNT_W+1)'(1)) < {1'b0, count_ff});
                     scl = (slot_ff == 2'd1);
                     if (slot_ff >= 2'd2) begin
                        byte_idx_in = byte_idx_ff + CNT_W'(1);
                        slot_in     = 2'd0;
                        if (byte_idx_in < count_ff) begin
                           shift_in = 8'd0;
                           bit_in   = 3'd0;
                           phase_in = PH_RECV;
                        end else begin
                           phase_in = PH_STOP;
                        end
                     end else begin
                        slot_in = slot_ff + 2'd1;
                     end
                  end
                  PH_STOP: begin
                     scl = (slot_ff != 2'd0);
                     sda = (slot_ff >= 2'd2);
                     if (slot_ff >= 2'd2) begin
                        done     = 1'b1;
                        busy     = 1'b0;
                        nerr     = nack_ff;
                        slot_in  = 2'd0;
                        phase_in = PH_IDLE;
                     end else begin
                        slot_in = slot_ff + 2'd1;
                     end
                  end
                  default: begin
                     scl      = scl_ff;
                     sda      = sda_ff;
                     busy     = 1'b0;
                     phase_in = PH_IDLE;
                     slot_in  = 2'd0;
                  end
               endcase
               scl_in = scl;
               sda_in = sda;
            end
            default: begin
            end
         endcase
      end

      rsp_data_in = rsp_data_ff;
      if (tick) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.scl_level  = scl;
         rsp_data_in.sda_level  = sda;
         rsp_data_in.read_data  = rd;
         rsp_data_in.read_valid = rd_v;
         rsp_data_in.busy_res   = busy;
         rsp_data_in.done_res   = done;
         rsp_data_in.nack_error = nerr;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         slot_ff      <= 2'd0;
         bit_ff       <= 3'd0;
         byte_idx_ff  <= '0;
         shift_ff     <= 8'd0;
         load_ptr_ff  <= '0;
         dir_ff       <= 1'b0;
         treg_ff      <= 8'd0;
         count_ff     <= '0;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
         stage_ff     <= STG_ADDRW;
         nack_ff      <= 1'b0;
         dev_addr_ff  <= DEV_ADDR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         slot_ff      <= slot_in;
         bit_ff       <= bit_in;
         byte_idx_ff  <= byte_idx_in;
         shift_ff     <= shift_in;
         load_ptr_ff  <= load_ptr_in;
         dir_ff       <= dir_in;
         treg_ff      <= treg_in;
         count_ff     <= count_in;
         scl_ff       <= scl_in;
         sda_ff       <= sda_in;
         stage_ff     <= stage_in;
         nack_ff      <= nack_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_if.valid && csr_if.ready) begin
            dev_addr_ff <= csr_if.data.device_address;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   // checks
   `I2CRA_ASSERT(a_nack_only_at_done, clock, reset,
      rsp_valid_ff && rsp_data_ff.nack_error |-> rsp_data_ff.done_res && !rsp_data_ff.busy_res,
      "nack_error outside the final STOP slot")
   `I2CRA_ASSERT(a_rx_only_on_read, clock, reset,
      rsp_valid_ff && rsp_data_ff.read_valid |-> dir_ff && rsp_data_ff.busy_res,
      "received byte strobe outside a read transaction")
   `I2CRA_ASSERT(a_byte_idx_in_range, clock, reset,
      (phase_ff != PH_IDLE) |-> (byte_idx_ff <= count_ff),
      "byte index beyond latched count")
   `I2CRA_ASSERT_NEXT(a_done_goes_idle, clock, reset,
      req_accept && tick && phase_ff == PH_STOP && slot_ff == 2'd2,
      phase_ff == PH_IDLE && scl_ff && sda_ff,
      "bus not released and idle after STOP")

endmodule

`default_nettype wire

// ----- tb/sv/tb_i2cra_slot_pkg.sv -----
// Slot predictor and scoreboard for the I2C register access master testbench.
// Depends on i2cra_pkg for the command, result and register types.
package tb_i2cra_slot_pkg;
   import i2cra_pkg::*;

   localparam int         BUF_DEPTH    = 8;
   localparam logic [1:0] OP_UNDEFINED = 2'd3;

   typedef enum logic [2:0] {
      BUS_IDLE,
      BUS_START,
      BUS_SEND,
      BUS_SEND_ACK,
      BUS_RECV,
      BUS_RECV_ACK,
      BUS_STOP
   } bus_phase_e;

   typedef enum logic [1:0] {
      XFER_ADDR_WR,
      XFER_REG,
      XFER_WDATA,
      XFER_ADDR_RD
   } xfer_stage_e;

   class i2c_slot_scoreboard;
      rsp_type     expected_slots[$];
      int          failures;
      int          slots_checked;
      int          bytes_read;
      int          transfers_done;
      int          nack_aborts;

      logic [6:0]  dev_addr;
      bus_phase_e  phase;
      xfer_stage_e stage;
      logic [1:0]  slot;
      logic [2:0]  bit_no;
      logic [3:0]  byte_no;
      logic [7:0]  shifter;
      logic [7:0]  tx_buffer [BUF_DEPTH];
      logic [3:0]  fill_ptr;
      logic        reading;
      logic [7:0]  reg_index;
      logic [3:0]  byte_total;
      logic        scl_q;
      logic        sda_q;
      logic        nacked;

      function new();
         dev_addr   = DEV_ADDR_RESET;
         phase      = BUS_IDLE;
         stage      = XFER_ADDR_WR;
         slot       = '0;
         bit_no     = '0;
         byte_no    = '0;
         shifter    = '0;
         fill_ptr   = '0;
         reading    = 1'b0;
         reg_index  = '0;
         byte_total = '0;
         scl_q      = 1'b1;
         sda_q      = 1'b1;
         nacked     = 1'b0;
      endfunction

      function void set_device_address(logic [6:0] addr);
         dev_addr = addr;
      endfunction

      function bit bus_idle();
         return phase == BUS_IDLE;
      endfunction

      // next tick lands on the slot where the target's ACK is sampled
      function bit samples_ack_next();
         return phase == BUS_SEND_ACK && slot == 2'd1;
      endfunction

      function int pending();
         return expected_slots.size();
      endfunction

      function void go_to(bus_phase_e p);
         slot  = '0;
         phase = p;
      endfunction

      function void load_shifter(logic [7:0] b);
         shifter = b;
         bit_no  = '0;
         go_to(BUS_SEND);
      endfunction

      function void after_ack();
         if (nacked) begin
            go_to(BUS_STOP);
            return;
         end
         case (stage)
            XFER_ADDR_WR: begin
               stage = XFER_REG;
               load_shifter(reg_index);
            end
            XFER_REG: begin
               if (reading) begin
                  stage = XFER_ADDR_RD;
                  go_to(BUS_START);
               end else if (byte_total == 4'd0) begin
                  go_to(BUS_STOP);
               end else begin
                  stage   = XFER_WDATA;
                  byte_no = '0;
                  load_shifter(tx_buffer[0]);
               end
            end
            XFER_WDATA: begin
               byte_no++;
               if (byte_no < byte_total && byte_no < BUF_DEPTH)
                  load_shifter(tx_buffer[byte_no[2:0]]);
               else
                  go_to(BUS_STOP);
            end
            default: begin
               if (byte_total == 4'd0) begin
                  go_to(BUS_STOP);
               end else begin
                  byte_no = '0;
                  bit_no  = '0;
                  shifter = '0;
                  go_to(BUS_RECV);
               end
            end
         endcase
      endfunction

      function rsp_type predict_tick(logic sda_in);
         rsp_type r;
         r           = '0;
         r.scl_level = 1'b1;
         r.sda_level = 1'b1;
         r.busy_res  = 1'b1;
         case (phase)
            BUS_START: begin
               r.scl_level = slot < 2'd2;
               r.sda_level = slot == 2'd0;
               if (slot >= 2'd2)
                  load_shifter({dev_addr, stage == XFER_ADDR_RD});
               else
                  slot++;
            end
            BUS_SEND: begin
               r.sda_level = (shifter & MSB_MASK) != 8'd0;
               r.scl_level = slot == 2'd1;
               if (slot >= 2'd2) begin
                  shifter = shifter << 1;
                  slot    = '0;
                  if (bit_no == 3'd7) begin
                     bit_no = '0;
                     phase  = BUS_SEND_ACK;
                  end else begin
                     bit_no++;
                  end
               end else begin
                  slot++;
               end
            end
            BUS_SEND_ACK: begin
               r.scl_level = slot == 2'd1;
               if (slot == 2'd1 && sda_in)
                  nacked = 1'b1;
               if (slot >= 2'd2) begin
                  slot = '0;
                  after_ack();
               end else begin
                  slot++;
               end
            end
            BUS_RECV: begin
               r.scl_level = slot == 2'd0;
               if (slot == 2'd0) begin
                  shifter = {shifter[6:0], sda_in};
                  if (bit_no == 3'd7) begin
                     r.read_valid = 1'b1;
                     r.read_data  = shifter;
                  end
                  slot = 2'd1;
               end else begin
                  slot = '0;
                  if (bit_no == 3'd7) begin
                     bit_no = '0;
                     phase  = BUS_RECV_ACK;
                  end else begin
                     bit_no++;
                  end
               end
            end
            BUS_RECV_ACK: begin
               // ACK every byte but the last, which gets a NACK
               r.sda_level = !((byte_no + 4'd1) < byte_total);
               r.scl_level = slot == 2'd1;
               if (slot >= 2'd2) begin
                  byte_no++;
                  if (byte_no < byte_total) begin
                     shifter = '0;
                     bit_no  = '0;
                     go_to(BUS_RECV);
                  end else begin
                     go_to(BUS_STOP);
                  end
               end else begin
                  slot++;
               end
            end
            BUS_STOP: begin
               r.scl_level = slot != 2'd0;
               r.sda_level = slot >= 2'd2;
               if (slot >= 2'd2) begin
                  r.done_res   = 1'b1;
                  r.busy_res   = 1'b0;
                  r.nack_error = nacked;
                  go_to(BUS_IDLE);
               end else begin
                  slot++;
               end
            end
            default: begin
               r.scl_level = scl_q;
               r.sda_level = sda_q;
               r.busy_res  = 1'b0;
               go_to(BUS_IDLE);
            end
         endcase
         scl_q = r.scl_level;
         sda_q = r.sda_level;
         return r;
      endfunction

      // called for every accepted command beat
      function void note_command(req_type cmd);
         case (cmd.op)
            OP_START: begin
               if (phase == BUS_IDLE) begin
                  reading    = cmd.read_not_write;
                  reg_index  = cmd.register_address;
                  byte_total = cmd.byte_count > BUF_DEPTH ? 4'(BUF_DEPTH) : cmd.byte_count;
                  fill_ptr   = '0;
                  nacked     = 1'b0;
                  byte_no    = '0;
                  stage      = XFER_ADDR_WR;
                  go_to(BUS_START);
               end
            end
            OP_LOAD: begin
               if (phase == BUS_IDLE && fill_ptr < BUF_DEPTH) begin
                  tx_buffer[fill_ptr[2:0]] = cmd.write_data;
                  fill_ptr++;
               end
            end
            OP_TICK: expected_slots.push_back(predict_tick(cmd.sda_sample));
            default: ;
         endcase
      endfunction

      function void compare_field(string name, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            failures++;
         end
      endfunction

      // called for every accepted result beat
      function void check_slot(rsp_type got);
         rsp_type want;
         if (expected_slots.size() == 0) begin
            $error("result beat with nothing expected: %h", got);
            failures++;
            return;
         end
         want = expected_slots.pop_front();
         slots_checked++;
         compare_field("scl_level", 8'(want.scl_level), 8'(got.scl_level));
         compare_field("sda_level", 8'(want.sda_level), 8'(got.sda_level));
         compare_field("read_data", want.read_data, got.read_data);
         compare_field("read_valid", 8'(want.read_valid), 8'(got.read_valid));
         compare_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
         compare_field("done_res", 8'(want.done_res), 8'(got.done_res));
         compare_field("nack_error", 8'(want.nack_error), 8'(got.nack_error));
         if (want.read_valid)
            bytes_read++;
         if (want.done_res)
            transfers_done++;
         if (want.nack_error)
            nack_aborts++;
      endfunction
   endclass

endpackage

// ----- tb/sv/tb_i2c_master_register_access.sv -----
// Top-level testbench for the I2C register access master: drives command,
// result and register channels, checks every slot against a predictor.
// Depends on i2cra_pkg, i2cra_chan_if, tb_i2cra_slot_pkg and the block itself.
module tb_i2c_master_register_access;
   import i2cra_pkg::*;
   import tb_i2cra_slot_pkg::*;

   localparam int HOLD_CYCLES   = 200;   // long receiver hold-off
   localparam int SETTLE_CYCLES = 4;     // output register plus margin
   localparam int ITEM_TARGET   = 1550;  // command beats over the whole run
   localparam int PHASE_ITEMS   = 40;
   localparam int MIN_PHASES    = 3;
   localparam int IDLE_PCT      = 32;
   localparam int NO_NACK       = -1;

   bit   clock;
   logic reset;

   i2cra_chan_if #(.payload_type(req_type)) req_if ();
   i2cra_chan_if #(.payload_type(rsp_type)) rsp_if ();
   i2cra_chan_if #(.payload_type(csr_type)) csr_if ();

   i2c_master_register_access uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   i2c_slot_scoreboard sb = new();

   bit steady;          // no idling on either side while set
   bit hold_due;        // asks the receiver for one long hold-off
   int items_sent;
   int items_ignored;   // beats the block drops (busy start/load, undefined op)
   int nack_at = NO_NACK;
   int acks_seen;
   int addr_settings;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Receiver: random stalls, none while steady, and one long hold-off on
   // request. The hold is counted here so the sender keeps pushing ticks and
   // the single output register fills and back-pressures req_if.
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_due) begin
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_due = 1'b0;
         end
         rsp_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // Result monitor: values read here are those seen by the block at this edge.
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         sb.check_slot(rsp_if.data);
   end

   function automatic req_type random_cmd(logic [1:0] op);
      req_type cmd;
      cmd.op               = op;
      cmd.read_not_write   = 1'($urandom);
      cmd.register_address = 8'($urandom);
      cmd.byte_count       = 4'($urandom);
      cmd.write_data       = 8'($urandom);
      cmd.sda_sample       = 1'($urandom);
      return cmd;
   endfunction

   // Offer one command beat, with random gaps ahead of it, and wait for it to
   // be taken. The predictor is told here, so the next beat is built knowing
   // exactly which bus slot it will drive.
   task automatic send_command(req_type cmd);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data  <= cmd;
      do @(posedge clock); while (!req_if.ready);
      sb.note_command(cmd);
      items_sent++;
   endtask

   // One timing slot. On ACK-sampling slots the target ACKs, except for the
   // one ACK picked to be a NACK; elsewhere SDA is random (read data bits).
   task automatic tick();
      req_type cmd;
      cmd = random_cmd(OP_TICK);
      if (sb.samples_ack_next()) begin
         cmd.sda_sample = (acks_seen == nack_at);
         acks_seen++;
      end
      send_command(cmd);
   endtask

   task automatic load_byte(logic [7:0] value);
      req_type cmd;
      cmd            = random_cmd(OP_LOAD);
      cmd.write_data = value;
      send_command(cmd);
   endtask

   task automatic load_bytes(int n);
      repeat (n) load_byte(8'($urandom));
   endtask

   // A beat the block should drop: start or load while busy, or undefined op.
   task automatic send_ignored(logic [1:0] op);
      send_command(random_cmd(op));
      items_ignored++;
   endtask

   // Start one transfer and tick it through to its STOP. nack_on picks which
   // target ACK (counted from the address byte) comes back as a NACK.
   task automatic run_transfer(bit rnw, logic [7:0] reg_idx, logic [3:0] count,
                               int nack_on, bit poke_busy);
      req_type cmd;
      int      noise;
      acks_seen              = 0;
      nack_at                = nack_on;
      cmd                    = random_cmd(OP_START);
      cmd.read_not_write     = rnw;
      cmd.register_address   = reg_idx;
      cmd.byte_count         = count;
      send_command(cmd);
      if (poke_busy) begin
         send_ignored(OP_START);
         send_ignored(OP_LOAD);
      end
      while (!sb.bus_idle()) begin
         if ($urandom_range(99) < 2) begin
            noise = $urandom_range(2);
            send_ignored(noise == 0 ? OP_START : noise == 1 ? OP_LOAD : OP_UNDEFINED);
         end else begin
            tick();
         end
      end
      // up to two idle slots after STOP
      repeat ($urandom_range(2)) tick();
   endtask

   // Mostly short transfers; a few at or above the buffer size. Writes always
   // load at least as many bytes as they send, sometimes more than fit.
   task automatic random_transfer();
      bit         rnw;
      int         pick;
      int         sent;
      logic [3:0] count;
      int         nack_on;
      rnw  = 1'($urandom);
      pick = $urandom_range(99);
      if (pick < 60)
         count = 4'($urandom_range(2));
      else if (pick < 85)
         count = 4'($urandom_range(8, 3));
      else
         count = 4'($urandom_range(15, 9));
      sent    = count > BUF_DEPTH ? BUF_DEPTH : count;
      nack_on = $urandom_range(99) < 15 ? $urandom_range(3) : NO_NACK;
      if ($urandom_range(9) == 0)
         send_ignored(OP_UNDEFINED);
      if (rnw)
         load_bytes($urandom_range(2));
      else
         load_bytes(sent + ($urandom_range(9) == 0 ? $urandom_range(3, 1) : 0));
      run_transfer(rnw, 8'($urandom), count, nack_on, $urandom_range(19) == 0);
   endtask

   // Stop offering, wait for every expected beat, then let the pipe empty.
   task automatic drain();
      req_if.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register writes only happen here, with the bus idle and nothing in flight.
   task automatic set_address(logic [6:0] addr);
      drain();
      csr_if.valid <= 1'b1;
      csr_if.data  <= csr_type'(addr);
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      sb.set_device_address(addr);
      addr_settings++;
   endtask

   initial begin
      int phase_no;
      int phase_base;
      reset        <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.data  <= '0;
      csr_if.valid <= 1'b0;
      csr_if.data  <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part, device address still at its reset value.
      tick();                                    // idle slots, bus released
      tick();
      send_ignored(OP_UNDEFINED);
      run_transfer(1'b0, 8'h00, 4'd0, NO_NACK, 1'b0);   // write of no data
      load_byte(8'h00);
      load_byte(8'hFF);
      run_transfer(1'b0, 8'hFF, 4'd2, NO_NACK, 1'b1);   // start/load while busy
      run_transfer(1'b1, 8'h5A, 4'd0, NO_NACK, 1'b0);   // read of no data
      run_transfer(1'b1, 8'hA5, 4'd15, NO_NACK, 1'b0);  // count clamped
      load_bytes(BUF_DEPTH + 1);                        // last load hits full buffer
      run_transfer(1'b0, 8'h3C, 4'd8, NO_NACK, 1'b0);
      load_bytes(1);
      run_transfer(1'b0, 8'h11, 4'd1, 0, 1'b0);         // NACK on address+W
      run_transfer(1'b1, 8'h22, 4'd2, 1, 1'b0);         // NACK on register
      load_bytes(3);
      run_transfer(1'b0, 8'h33, 4'd3, 3, 1'b0);         // NACK on a data byte
      run_transfer(1'b1, 8'h44, 4'd1, 2, 1'b0);         // NACK on address+R

      // Random part in phases, each with its own device address; one phase
      // runs with no idling, the next one carries the long hold-off.
      phase_no = 0;
      while (items_sent < ITEM_TARGET || phase_no < MIN_PHASES) begin
         set_address(phase_no == 0 ? 7'h7F : phase_no == 1 ? 7'h00 : 7'($urandom_range(127)));
         steady     = (phase_no == 1);
         hold_due   = (phase_no == 2);
         phase_base = items_sent - items_ignored;
         while (items_sent - items_ignored - phase_base < PHASE_ITEMS)
            random_transfer();
         steady = 1'b0;
         phase_no++;
      end
      drain();

      $display("Checked %0d bus slots over %0d transfers: %0d bytes read, %0d NACK aborts.",
               sb.slots_checked, sb.transfers_done, sb.bytes_read, sb.nack_aborts);
      $display("Ran %0d device address settings under random stalls and a long hold-off.",
               addr_settings + 1);
      if (sb.failures == 0)
         $display("[i2c_master_register_access] OK");
      else
         $display("[i2c_master_register_access] ERROR");
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #2000000;
      $display("[i2c_master_register_access] ERROR");
      $finish;
   end

endmodule
